// ===== rtl/ocbs_pkg.sv =====
`default_nettype none

package ocbs_pkg;

  // Ring geometry and fixed field widths.
  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int ACT_W   = 3;
  localparam int LEN_W   = 16;

  localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(DEPTH);

  // Action codes of an input item.
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH     = 3'd0,
    ACT_POP_NEW  = 3'd1,
    ACT_POP_OLD  = 3'd2,
    ACT_PEEK_NEW = 3'd3,
    ACT_PEEK_OLD = 3'd4,
    ACT_BLK_READ = 3'd5,
    ACT_BLK_TEST = 3'd6
  } action_t;

  // Input item.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_byte;
    logic [FILL_W-1:0] count;
  } item_t;

  // Result item.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic [FILL_W-1:0] done_count;
    logic              last;
    logic              block_empty;
    logic              block_fail;
  } result_t;

  // Result fields known when the ring read is issued; the byte comes later from the registered read port.
  typedef struct packed {
    logic              has_byte;
    logic [FILL_W-1:0] done_count;
    logic              last;
    logic              block_empty;
    logic              block_fail;
  } res_tag_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_LO,
    ST_HDR_HI,
    ST_HDR_EVAL,
    ST_STREAM
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_HDR_LO,
    OP_HDR_HI,
    OP_HDR_EVAL,
    OP_STREAM
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic go_stream;
    logic go_hdr;
    logic hdr_to_stream;
    logic stream_last;
  } dp_status_t;

  // Slot k places below base, modulo DEPTH (k in 0..DEPTH).
  function automatic logic [IDX_W-1:0] idx_back(input logic [IDX_W-1:0] base,
                                                input logic [FILL_W-1:0] k);
    logic [FILL_W:0] sum;
    sum = (FILL_W+1)'(base) + (FILL_W+1)'(DEPTH) - (FILL_W+1)'(k);
    if (sum >= (FILL_W+1)'(DEPTH)) begin
      sum = sum - (FILL_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] base);
    return (base == IDX_W'(DEPTH - 1)) ? '0 : base + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] base);
    return (base == '0) ? IDX_W'(DEPTH - 1) : base - 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ocbs_ram.sv =====
`default_nettype none

module ocbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                          wdata,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: write when enabled, registered read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/ocbs_ctrl.sv =====
`default_nettype none

module ocbs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire ocbs_pkg::dp_status_t status,
  output ocbs_pkg::dp_cmd_t        cmd,
  output logic                     busy
);

  import ocbs_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && status.go_stream) begin
          state_next = ST_STREAM;
        end else if (start && status.go_hdr) begin
          state_next = ST_HDR_LO;
        end
      end
      ST_HDR_LO:   state_next = ST_HDR_HI;
      ST_HDR_HI:   state_next = ST_HDR_EVAL;
      ST_HDR_EVAL: state_next = status.hdr_to_stream ? ST_STREAM : ST_IDLE;
      ST_STREAM:   state_next = status.stream_last ? ST_IDLE : ST_STREAM;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs: one datapath operation per cycle.
  always_comb begin
    busy   = 1'b1;
    cmd.op = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        busy   = 1'b0;
        cmd.op = start ? OP_ACCEPT : OP_NONE;
      end
      ST_HDR_LO:   cmd.op = OP_HDR_LO;
      ST_HDR_HI:   cmd.op = OP_HDR_HI;
      ST_HDR_EVAL: cmd.op = OP_HDR_EVAL;
      ST_STREAM:   cmd.op = OP_STREAM;
      default:     cmd.op = OP_NONE;
    endcase
  end

`ifndef ASSERT_OFF
  // The header is always read as three consecutive steps.
  a_hdr_seq: assert property (@(posedge clk) disable iff (rst)
    state == ST_HDR_LO |=> state == ST_HDR_HI ##1 state == ST_HDR_EVAL)
    else $error("header read sequence broken");
`endif

endmodule

`default_nettype wire

// ===== rtl/ocbs_dpath.sv =====
`default_nettype none

module ocbs_dpath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ocbs_pkg::item_t      item,
  input  wire ocbs_pkg::dp_cmd_t    cmd,
  output ocbs_pkg::dp_status_t      status,
  output logic                      strobe,
  output ocbs_pkg::result_t         result
);

  import ocbs_pkg::*;

  // Stack pointer and fill level.
  logic [IDX_W-1:0]  top, top_next;
  logic [FILL_W-1:0] fill, fill_next;

  // Transfer state: ring pointer, bytes left, direction and shared result fields.
  logic [IDX_W-1:0]  ptr, ptr_next;
  logic [FILL_W-1:0] remain, remain_next;
  logic              newest, newest_next;
  logic [FILL_W-1:0] s_done, s_done_next;
  logic              s_fail, s_fail_next;
  logic              test_mode, test_mode_next;
  logic [FILL_W-1:0] cap, cap_next;
  logic [BYTE_W-1:0] lo, lo_next;

  // Pending result.
  logic     tag_valid, tag_valid_next;
  res_tag_t tag, tag_next;

  // Ring memory port.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [BYTE_W-1:0] rdata;

  // Decoded item.
  logic              is_take, is_new, is_pop, is_blk, fill_ge2;
  logic [FILL_W-1:0] take_n;

  // Header evaluation.
  logic [LEN_W-1:0]  hdr_len;
  logic              len_gt_cap;
  logic              len_gt_fill;
  logic [FILL_W-1:0] hdr_n;
  logic [LEN_W:0]    len_p2;

  ocbs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (item.data_byte),
    .rdata (rdata)
  );

  // Item decode and clamped byte count.
  always_comb begin
    is_take  = (item.action == ACT_POP_NEW) || (item.action == ACT_POP_OLD) ||
               (item.action == ACT_PEEK_NEW) || (item.action == ACT_PEEK_OLD);
    is_new   = (item.action == ACT_POP_NEW) || (item.action == ACT_PEEK_NEW);
    is_pop   = (item.action == ACT_POP_NEW) || (item.action == ACT_POP_OLD);
    is_blk   = (item.action == ACT_BLK_READ) || (item.action == ACT_BLK_TEST);
    fill_ge2 = fill >= FILL_W'(2);
    take_n   = (item.count < fill) ? item.count : fill;
  end

  // Header fields: low byte captured earlier, high byte straight from the ring.
  always_comb begin
    hdr_len     = {rdata, lo};
    len_gt_cap  = hdr_len > LEN_W'(cap);
    len_gt_fill = hdr_len > LEN_W'(fill);
    hdr_n       = len_gt_fill ? fill : hdr_len[FILL_W-1:0];
    len_p2      = (LEN_W+1)'(hdr_len) + (LEN_W+1)'(2);
  end

  // Status for the controller.
  always_comb begin
    status.go_stream     = is_take && (take_n != '0);
    status.go_hdr        = is_blk && fill_ge2;
    status.hdr_to_stream = !test_mode && !len_gt_cap && (hdr_n != '0);
    status.stream_last   = remain == FILL_W'(1);
  end

  // Operation logic.
  always_comb begin
    top_next       = top;
    fill_next      = fill;
    ptr_next       = ptr;
    remain_next    = remain;
    newest_next    = newest;
    s_done_next    = s_done;
    s_fail_next    = s_fail;
    test_mode_next = test_mode;
    cap_next       = cap;
    lo_next        = lo;
    tag_valid_next = 1'b0;
    tag_next       = '0;
    tag_next.last  = 1'b1;
    ram_we         = 1'b0;
    ram_addr       = ptr;

    unique case (cmd.op)
      OP_NONE: begin
      end

      OP_ACCEPT: begin
        unique case (item.action)
          ACT_PUSH: begin
            ram_we         = 1'b1;
            ram_addr       = top;
            top_next       = idx_inc(top);
            fill_next      = (fill == DEPTH_FILL) ? fill : fill + 1'b1;
            tag_valid_next = 1'b1;
          end
          ACT_POP_NEW, ACT_POP_OLD, ACT_PEEK_NEW, ACT_PEEK_OLD: begin
            if (take_n == '0) begin
              tag_valid_next = 1'b1;
            end else begin
              remain_next = take_n;
              s_done_next = take_n;
              s_fail_next = 1'b0;
              newest_next = is_new;
              ptr_next    = is_new ? idx_back(top, FILL_W'(1)) : idx_back(top, take_n);
              if (is_pop) begin
                top_next  = idx_back(top, take_n);
                fill_next = fill - take_n;
              end
            end
          end
          ACT_BLK_READ: begin
            if (!fill_ge2) begin
              // Length missing: drop what is held and fail.
              top_next            = idx_back(top, fill);
              fill_next           = '0;
              tag_valid_next      = 1'b1;
              tag_next.block_fail = 1'b1;
            end else begin
              ptr_next       = idx_back(top, FILL_W'(2));
              top_next       = idx_back(top, FILL_W'(2));
              fill_next      = fill - FILL_W'(2);
              test_mode_next = 1'b0;
              cap_next       = item.count;
            end
          end
          ACT_BLK_TEST: begin
            if (!fill_ge2) begin
              tag_valid_next       = 1'b1;
              tag_next.block_empty = 1'b1;
            end else begin
              ptr_next       = idx_back(top, FILL_W'(2));
              test_mode_next = 1'b1;
            end
          end
          default: begin
            tag_valid_next = 1'b1;
          end
        endcase
      end

      OP_HDR_LO: begin
        ptr_next = idx_inc(ptr);
      end

      OP_HDR_HI: begin
        lo_next = rdata;
      end

      OP_HDR_EVAL: begin
        if (test_mode) begin
          tag_valid_next       = 1'b1;
          tag_next.block_empty = (LEN_W+1)'(fill) < len_p2;
        end else if (len_gt_cap) begin
          // Block too large: discard its bytes.
          top_next            = idx_back(top, hdr_n);
          fill_next           = fill - hdr_n;
          tag_valid_next      = 1'b1;
          tag_next.block_fail = 1'b1;
        end else if (hdr_n == '0) begin
          tag_valid_next      = 1'b1;
          tag_next.block_fail = hdr_len != '0;
        end else begin
          remain_next = hdr_n;
          newest_next = 1'b0;
          ptr_next    = idx_back(top, hdr_n);
          top_next    = idx_back(top, hdr_n);
          fill_next   = fill - hdr_n;
          s_done_next = len_gt_fill ? '0 : hdr_len[FILL_W-1:0];
          s_fail_next = len_gt_fill;
        end
      end

      OP_STREAM: begin
        ptr_next            = newest ? idx_dec(ptr) : idx_inc(ptr);
        remain_next         = remain - 1'b1;
        tag_valid_next      = 1'b1;
        tag_next.has_byte   = 1'b1;
        tag_next.done_count = s_done;
        tag_next.last       = remain == FILL_W'(1);
        tag_next.block_fail = s_fail;
      end

      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      top       <= '0;
      fill      <= '0;
      remain    <= '0;
      tag_valid <= 1'b0;
    end else begin
      top       <= top_next;
      fill      <= fill_next;
      remain    <= remain_next;
      tag_valid <= tag_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr       <= ptr_next;
    newest    <= newest_next;
    s_done    <= s_done_next;
    s_fail    <= s_fail_next;
    test_mode <= test_mode_next;
    cap       <= cap_next;
    lo        <= lo_next;
    tag       <= tag_next;
  end

  // Result assembly: the ring byte arrives with the registered tag.
  always_comb begin
    strobe             = tag_valid;
    result.out_byte    = tag.has_byte ? rdata : '0;
    result.has_byte    = tag.has_byte;
    result.done_count  = tag.done_count;
    result.last        = tag.last;
    result.block_empty = tag.block_empty;
    result.block_fail  = tag.block_fail;
  end

`ifndef ASSERT_OFF
  // The fill level never passes the ring size.
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_FILL)
    else $error("fill level above ring size");

  // A byte transfer never starts with nothing left.
  a_stream_remain: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_STREAM |-> remain != '0)
    else $error("byte transfer with no bytes left");

  // Results of one action come in consecutive cycles up to the last one.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    tag_valid && !tag.last |=> tag_valid && tag.has_byte)
    else $error("gap inside a multi-byte action");
`endif

endmodule

`default_nettype wire

// ===== rtl/overwriting_circular_byte_stack.sv =====
`default_nettype none

// Channel  Dir  Handshake                    Payload
// item     in   start high while busy low    ocbs_pkg::item_t
// result   out  strobe, one per result       ocbs_pkg::result_t
//
// Push and actions that return a single result straight away leave the block idle.
// A push may follow every cycle.
// Pop and peek stream their n bytes one byte per cycle from the ring RAM port.
// Block test and block read answer straight away with fewer than two bytes held, else
// they read the header and evaluate it; a passing block read then streams its bytes.
// Each result appears in the cycle after its ring read, on the registered read port.
// Synchronous rst clears the stack pointer and fill level; ring contents are kept.
// The receiver cannot stall: every result is taken in its strobe cycle.

module overwriting_circular_byte_stack (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire ocbs_pkg::item_t   item,
  output logic                   busy,
  output logic                   strobe,
  output ocbs_pkg::result_t      result
);

  import ocbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ocbs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ocbs_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

`ifndef ASSERT_OFF
  // Once the block is idle, any result still showing closes its action.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    !busy && strobe |-> result.last)
    else $error("idle with an action still open");
`endif

endmodule

`default_nettype wire

// ===== dv/overwriting_circular_byte_stack_tb.sv =====
`timescale 1ns / 100ps

module overwriting_circular_byte_stack_tb;
  import ocbs_pkg::*;

  // The action field has one code beyond the last defined action.
  localparam logic [ACT_W-1:0] ACT_SPARE = 3'd7;
  localparam int ITEM_W = $bits(item_t);
  localparam int RANDOM_ITEMS = 240;
  localparam int DRAIN_CYCLES = 16;

  // One stimulus row: the item, and a typed reply where it is known in advance.
  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
    bit      steady;
  } stim_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    strobe;
  result_t result;

  // Sideband that travels with the item on the driven cycle.
  bit      row_typed;
  result_t row_want;

  stim_row_t stim_rows[$];
  result_t   pending_replies[$];
  result_t   step_replies[$];

  // Shadow copy of the byte ring.
  logic [BYTE_W-1:0] ring_shadow [0:DEPTH-1];
  logic [BYTE_W-1:0] taken [0:DEPTH-1];
  int top_shadow;
  int fill_shadow;
  int max_fill;

  int mismatches;
  int checked_replies;
  int accepted_items;
  int directed_rows;

  overwriting_circular_byte_stack i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  function automatic result_t reply(int b, int has, int done, int last, int empty,
                                    int fail);
    result_t r;
    r.out_byte    = BYTE_W'(b);
    r.has_byte    = 1'(has);
    r.done_count  = FILL_W'(done);
    r.last        = 1'(last);
    r.block_empty = 1'(empty);
    r.block_fail  = 1'(fail);
    return r;
  endfunction

  function automatic int slot_back(int k);
    return (top_shadow + DEPTH - k) % DEPTH;
  endfunction

  // Copy up to want newest bytes into taken, in the order asked; optionally consume them.
  task automatic take_bytes(input int want, input bit newest_first, input bit consume,
                            output int got);
    int k;
    got = (want > fill_shadow) ? fill_shadow : want;
    for (int i = 0; i < got; i++) begin
      k = newest_first ? i + 1 : got - i;
      taken[i] = ring_shadow[slot_back(k)];
    end
    if (consume) begin
      top_shadow = slot_back(got);
      fill_shadow -= got;
    end
  endtask

  task automatic emit_bytes(input int n, input int done, input int fail);
    if (n == 0) begin
      step_replies.push_back(reply(0, 0, done, 1, 0, fail));
    end else begin
      for (int i = 0; i < n; i++) begin
        step_replies.push_back(reply(taken[i], 1, done, (i == n - 1) ? 1 : 0, 0, fail));
      end
    end
  endtask

  // Work out the replies to one accepted item and advance the shadow stack.
  task automatic stack_step(input item_t it);
    int got;
    int len;
    bit newest_first;
    bit consume;
    step_replies.delete();
    case (it.action)
      ACT_PUSH: begin
        ring_shadow[top_shadow] = it.data_byte;
        top_shadow = (top_shadow + 1) % DEPTH;
        if (fill_shadow < DEPTH) begin
          fill_shadow++;
        end
        step_replies.push_back(reply(0, 0, 0, 1, 0, 0));
      end
      ACT_POP_NEW, ACT_POP_OLD, ACT_PEEK_NEW, ACT_PEEK_OLD: begin
        newest_first = (it.action == ACT_POP_NEW) || (it.action == ACT_PEEK_NEW);
        consume = (it.action == ACT_POP_NEW) || (it.action == ACT_POP_OLD);
        take_bytes(it.count, newest_first, consume, got);
        emit_bytes(got, got, 0);
      end
      ACT_BLK_READ: begin
        take_bytes(2, 1'b0, 1'b1, got);
        if (got != 2) begin
          step_replies.push_back(reply(0, 0, 0, 1, 0, 1));
        end else begin
          // The older header byte is the low byte of the length.
          len = int'({taken[1], taken[0]});
          take_bytes(len, 1'b0, 1'b1, got);
          if (len > it.count) begin
            step_replies.push_back(reply(0, 0, 0, 1, 0, 1));
          end else if (got == len) begin
            emit_bytes(got, len, 0);
          end else begin
            emit_bytes(got, 0, 1);
          end
        end
      end
      ACT_BLK_TEST: begin
        if (fill_shadow < 2) begin
          step_replies.push_back(reply(0, 0, 0, 1, 1, 0));
        end else begin
          take_bytes(2, 1'b0, 1'b0, got);
          len = int'({taken[1], taken[0]});
          step_replies.push_back(reply(0, 0, 0, 1, (fill_shadow < len + 2) ? 1 : 0, 0));
        end
      end
      default: begin
        step_replies.push_back(reply(0, 0, 0, 1, 0, 0));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Check each reply against the oldest expectation, then predict for a new item.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (strobe !== 1'b0) begin
        if (pending_replies.size() == 0) begin
          $error("unexpected reply %h with nothing pending", result);
          mismatches++;
        end else begin
          want = pending_replies.pop_front();
          check_field("out_byte", want.out_byte, result.out_byte);
          check_field("has_byte", BYTE_W'(want.has_byte), BYTE_W'(result.has_byte));
          check_field("done_count", BYTE_W'(want.done_count), BYTE_W'(result.done_count));
          check_field("last", BYTE_W'(want.last), BYTE_W'(result.last));
          check_field("block_empty", BYTE_W'(want.block_empty), BYTE_W'(result.block_empty));
          check_field("block_fail", BYTE_W'(want.block_fail), BYTE_W'(result.block_fail));
          checked_replies++;
        end
      end
      if (start && !busy) begin
        stack_step(item);
        if (row_typed) begin
          pending_replies.push_back(row_want);
        end else begin
          foreach (step_replies[i]) begin
            pending_replies.push_back(step_replies[i]);
          end
        end
        if (fill_shadow > max_fill) begin
          max_fill = fill_shadow;
        end
        accepted_items++;
      end
    end
  end

  task automatic add_row(input logic [ACT_W-1:0] act, input int data, input int cnt,
                         input bit typed, input result_t want);
    stim_row_t r;
    r.it.action    = act;
    r.it.data_byte = BYTE_W'(data);
    r.it.count     = FILL_W'(cnt);
    r.typed        = typed;
    r.want         = want;
    r.steady       = 1'b0;
    stim_rows.push_back(r);
  endtask

  task automatic add_item(input logic [ACT_W-1:0] act, input int data, input int cnt);
    add_row(act, data, cnt, 1'b0, '0);
  endtask

  // Random count for pop and peek: mostly small, sometimes the ring depth or any 7-bit value.
  function automatic int pick_count();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return DEPTH;
    end else if (sel == 1) begin
      return $urandom_range(0, 127);
    end
    return $urandom_range(0, 10);
  endfunction

  // Random part: mostly framed blocks and push bursts, with pops, peeks and noise.
  task automatic build_random_rows();
    int first;
    int sel;
    int len;
    int claimed;
    int cap;
    int burst;
    first = stim_rows.size();
    while (stim_rows.size() - first < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          add_item(ACT_PUSH, $urandom_range(0, 255), $urandom_range(0, 127));
        end
        claimed = len;
        case ($urandom_range(0, 9))
          0: claimed = $urandom_range(0, 65535);
          1, 2: claimed = len + $urandom_range(1, 4);
          default: claimed = len;
        endcase
        add_item(ACT_PUSH, claimed & 8'hff, $urandom_range(0, 127));
        add_item(ACT_PUSH, claimed >> 8, $urandom_range(0, 127));
        if ($urandom_range(0, 1) == 1) begin
          add_item(ACT_BLK_TEST, $urandom_range(0, 255), $urandom_range(0, 127));
        end
        if (claimed > 127) begin
          cap = $urandom_range(0, 127);
        end else if (claimed > 0 && $urandom_range(0, 5) == 0) begin
          cap = claimed - 1;
        end else begin
          cap = claimed + $urandom_range(0, 5);
          if (cap > 127) begin
            cap = 127;
          end
        end
        add_item(ACT_BLK_READ, $urandom_range(0, 255), cap);
      end else if (sel < 55) begin
        // An occasional long burst wraps the ring and overwrites old bytes.
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 10);
        for (int i = 0; i < burst; i++) begin
          add_item(ACT_PUSH, $urandom_range(0, 255), $urandom_range(0, 127));
        end
      end else if (sel < 85) begin
        add_item(ACT_W'(ACT_POP_NEW + $urandom_range(0, 3)), $urandom_range(0, 255),
                 pick_count());
      end else if (sel < 95) begin
        add_item(($urandom_range(0, 1) == 1) ? ACT_BLK_TEST : ACT_BLK_READ,
                 $urandom_range(0, 255), $urandom_range(0, 127));
      end else begin
        add_item(ACT_SPARE, $urandom_range(0, 255), $urandom_range(0, 127));
      end
    end
    // A long stretch in the middle runs without any gaps.
    for (int i = first + RANDOM_ITEMS / 3; i < first + RANDOM_ITEMS / 2; i++) begin
      stim_rows[i].steady = 1'b1;
    end
  endtask

  // Reset, directed table, random items, then drain and report.
  initial begin
    result_t none_left;
    result_t pushed;
    result_t failed;
    result_t no_block;
    none_left = reply(0, 0, 0, 1, 0, 0);
    pushed    = reply(0, 0, 0, 1, 0, 0);
    failed    = reply(0, 0, 0, 1, 0, 1);
    no_block  = reply(0, 0, 0, 1, 1, 0);
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    row_typed = 1'b0;
    row_want = '0;
    top_shadow = 0;
    fill_shadow = 0;
    max_fill = 0;
    mismatches = 0;
    checked_replies = 0;
    accepted_items = 0;

    // Directed table: empty stack, missing length, framed block, oversize, empty and short blocks.
    add_row(ACT_POP_OLD, 8'h00, 5, 1'b1, none_left);
    add_row(ACT_BLK_TEST, 8'h00, 0, 1'b1, no_block);
    add_row(ACT_BLK_READ, 8'h00, 0, 1'b1, failed);
    add_row(ACT_PUSH, 8'h00, 0, 1'b1, pushed);
    add_row(ACT_BLK_READ, 8'hff, 127, 1'b1, failed);
    add_row(ACT_PUSH, 8'hff, 127, 1'b1, pushed);
    add_item(ACT_PUSH, 8'haa, 0);
    add_item(ACT_PUSH, 8'h55, 0);
    add_item(ACT_PUSH, 8'h81, 0);
    add_item(ACT_PUSH, 8'h03, 0);
    add_item(ACT_PUSH, 8'h00, 0);
    add_item(ACT_BLK_TEST, 8'h00, 0);
    add_item(ACT_BLK_READ, 8'h00, 3);
    add_row(ACT_PEEK_NEW, 8'h00, 0, 1'b1, none_left);
    add_item(ACT_POP_NEW, 8'h00, DEPTH);
    add_item(ACT_PUSH, 8'h10, 0);
    add_item(ACT_PUSH, 8'h20, 0);
    add_row(ACT_BLK_READ, 8'h00, DEPTH, 1'b1, failed);
    add_item(ACT_PUSH, 8'h00, 0);
    add_item(ACT_PUSH, 8'h00, 0);
    add_row(ACT_BLK_READ, 8'h00, 0, 1'b1, none_left);
    add_item(ACT_PUSH, 8'h11, 0);
    add_item(ACT_PUSH, 8'h05, 0);
    add_item(ACT_PEEK_OLD, 8'h00, 2);
    add_item(ACT_PUSH, 8'h00, 0);
    add_item(ACT_BLK_READ, 8'h00, 10);
    add_row(ACT_SPARE, 8'hff, 127, 1'b1, none_left);
    directed_rows = stim_rows.size();
    build_random_rows();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[n]) begin
      // Random gaps before the item, except in the steady stretch.
      while (!stim_rows[n].steady && $urandom_range(0, 99) < 29) begin
        start <= 1'b0;
        item <= ITEM_W'($urandom);
        @(negedge clk);
      end
      start <= 1'b1;
      item <= stim_rows[n].it;
      row_typed <= stim_rows[n].typed;
      row_want <= stim_rows[n].want;
      @(posedge clk);
      while (busy) begin
        @(posedge clk);
      end
      @(negedge clk);
    end
    start <= 1'b0;

    while (pending_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d directed) and checked %0d replies.",
             accepted_items, directed_rows, checked_replies);
    $display("Highest fill level seen: %0d of %0d; mismatches: %0d.",
             max_fill, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ocbs_pkg.sv
rtl/ocbs_ram.sv
rtl/ocbs_ctrl.sv
rtl/ocbs_dpath.sv
rtl/overwriting_circular_byte_stack.sv
dv/overwriting_circular_byte_stack_tb.sv
